// ===== rtl/ce_pkg.sv =====
// Shared beat types and fixed-point constants for the complex exponential pipeline.
`default_nettype none
package ce_pkg;

  typedef struct packed {
    logic signed [15:0] real_in;
    logic signed [15:0] imag_in;
  } arg_t;

  typedef struct packed {
    logic signed [31:0] real_out;
    logic signed [31:0] imag_out;
  } res_t;

  localparam logic [30:0] ONE_Q30        = 31'd1073741824;
  localparam logic [30:0] LN2_Q30        = 31'd744261118;
  localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
  localparam logic [30:0] QUARTER_PI_Q30 = 31'd843314857;

endpackage
`default_nettype wire

// ===== rtl/complex_exponential.sv =====
// Top level: pipelined exp(x)*cos(y), exp(x)*sin(y) in fixed point.
// Throughput: one beat per cycle while res_stall is low; each Horner term is one three-stage multiply-divide step.
// Each stage loads when empty or when the next stage loads, so bubbles close under stall.
// Reset: synchronous rst clears all stage valid bits; data registers are not reset.
`default_nettype none
module complex_exponential import ce_pkg::*; #(
  parameter int IN_FRAC_BITS      = 12,
  parameter int OUT_FRAC_BITS     = 16,
  parameter int APPROX_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic arg_valid,
  output logic arg_stall,
  input  arg_t arg,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int AI  = APPROX_ITERATIONS;
  localparam int KW  = 18 - IN_FRAC_BITS;
  localparam int SHW = KW + 3;
  localparam int HE  = 5 + 3 * AI;
  localparam int NS  = HE + 4;

  typedef struct packed {
    logic [29:0]           g;
    logic [1:0]            quad;
    logic                  swap;
    logic signed [SHW-1:0] sh;
  } side_t;

  logic [NS:1]   v;
  logic [NS:1]   vprev;
  logic [NS+1:1] en;

  assign en[NS+1]  = !res_stall;
  assign vprev     = {v[NS-1:1], arg_valid};
  assign arg_stall = !en[1];
  assign res_valid = v[NS];

  for (genvar i = 1; i <= NS; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (en[i]) v[i] <= vprev[i];
      end
    end
  end

  // range reduction
  logic signed [KW-1:0] kq;
  logic [30:0]          xr;
  logic signed [KW-1:0] aq;
  logic [30:0]          af;

  ce_recip #(.IN_FRAC_BITS(IN_FRAC_BITS), .KW(KW), .DIVISOR(LN2_Q30)) u_xred (
    .clk(clk), .en(en[3:1]), .a(arg.real_in), .quo(kq), .rem(xr)
  );

  ce_recip #(.IN_FRAC_BITS(IN_FRAC_BITS), .KW(KW), .DIVISOR(HALF_PI_Q30)) u_yred (
    .clk(clk), .en(en[3:1]), .a(arg.imag_in), .quo(aq), .rem(af)
  );

  // fold angle into the first octant
  logic [29:0]           r4;
  logic [29:0]           g4;
  logic [1:0]            quad4;
  logic                  swap4;
  logic signed [SHW-1:0] sh4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r4    <= xr[29:0];
      quad4 <= aq[1:0];
      sh4   <= SHW'(60 - OUT_FRAC_BITS) - SHW'(kq);
      if (af > QUARTER_PI_Q30) begin
        g4    <= 30'(HALF_PI_Q30 - af);
        swap4 <= 1'b1;
      end else begin
        g4    <= af[29:0];
        swap4 <= 1'b0;
      end
    end
  end

  // square the angle
  logic [59:0] gsq;
  logic [29:0] r5;
  logic [29:0] g2_5;
  side_t       sd [0:3*AI];

  assign gsq = 60'(g4) * 60'(g4);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r5    <= r4;
      g2_5  <= gsq[59:30];
      sd[0] <= '{g: g4, quad: quad4, swap: swap4, sh: sh4};
    end
  end

  for (genvar i = 1; i <= 3 * AI; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[5+i]) sd[i] <= sd[i-1];
    end
  end

  // Horner chains
  logic [30:0] e_acc [0:AI];
  logic [29:0] e_m   [0:AI];
  logic [30:0] s_acc [0:AI];
  logic [29:0] s_m   [0:AI];
  logic [30:0] c_acc [0:AI];
  logic [29:0] c_m   [0:AI];

  assign e_acc[0] = ONE_Q30;
  assign e_m[0]   = r5;
  assign s_acc[0] = ONE_Q30;
  assign s_m[0]   = g2_5;
  assign c_acc[0] = ONE_Q30;
  assign c_m[0]   = g2_5;

  for (genvar i = 0; i < AI; i++) begin : g_horner
    localparam int unsigned JJ = AI - i;

    ce_hstep #(.DIV(JJ), .ADD(1'b1)) u_exp (
      .clk(clk), .en(en[6+3*i +: 3]),
      .acc_in(e_acc[i]), .m_in(e_m[i]), .acc_out(e_acc[i+1]), .m_out(e_m[i+1])
    );

    ce_hstep #(.DIV(2 * JJ * (2 * JJ + 1)), .ADD(1'b0)) u_sin (
      .clk(clk), .en(en[6+3*i +: 3]),
      .acc_in(s_acc[i]), .m_in(s_m[i]), .acc_out(s_acc[i+1]), .m_out(s_m[i+1])
    );

    ce_hstep #(.DIV((2 * JJ - 1) * 2 * JJ), .ADD(1'b0)) u_cos (
      .clk(clk), .en(en[6+3*i +: 3]),
      .acc_in(c_acc[i]), .m_in(c_m[i]), .acc_out(c_acc[i+1]), .m_out(c_m[i+1])
    );
  end

  // finish sine, undo octant fold
  logic [60:0]           sprod;
  logic [30:0]           tc_a;
  logic [30:0]           ts_a;
  logic [30:0]           mag_a;
  logic [1:0]            quad_a;
  logic signed [SHW-1:0] sh_a;

  assign sprod = 61'(s_acc[AI]) * 61'(sd[3*AI].g);

  always_ff @(posedge clk) begin
    if (en[HE+1]) begin
      mag_a  <= e_acc[AI];
      quad_a <= sd[3*AI].quad;
      sh_a   <= sd[3*AI].sh;
      if (sd[3*AI].swap) begin
        tc_a <= sprod[60:30];
        ts_a <= c_acc[AI];
      end else begin
        tc_a <= c_acc[AI];
        ts_a <= sprod[60:30];
      end
    end
  end

  // quadrant select and scale by magnitude
  logic [61:0]           p_re;
  logic [61:0]           p_im;
  logic                  neg_re_b;
  logic                  neg_im_b;
  logic signed [SHW-1:0] sh_b;

  always_ff @(posedge clk) begin
    if (en[HE+2]) begin
      p_re     <= 62'(mag_a) * 62'(quad_a[0] ? ts_a : tc_a);
      p_im     <= 62'(mag_a) * 62'(quad_a[0] ? tc_a : ts_a);
      neg_re_b <= quad_a[1] ^ quad_a[0];
      neg_im_b <= quad_a[1];
      sh_b     <= sh_a;
    end
  end

  // shift to output scale
  logic        sh_ok;
  logic [61:0] re_sh;
  logic [61:0] im_sh;
  logic [32:0] v_re;
  logic [32:0] v_im;
  logic        big_re;
  logic        big_im;
  logic        neg_re_c;
  logic        neg_im_c;

  assign sh_ok = (sh_b >= 0) && (sh_b <= SHW'(63));
  assign re_sh = sh_ok ? p_re >> sh_b[5:0] : '0;
  assign im_sh = sh_ok ? p_im >> sh_b[5:0] : '0;

  always_ff @(posedge clk) begin
    if (en[HE+3]) begin
      v_re     <= re_sh[32:0];
      v_im     <= im_sh[32:0];
      big_re   <= |re_sh[61:33];
      big_im   <= |im_sh[61:33];
      neg_re_c <= neg_re_b;
      neg_im_c <= neg_im_b;
    end
  end

  // saturate and apply sign
  function automatic logic [31:0] sat_sign(input logic [32:0] val, input logic big,
                                           input logic neg);
    logic [31:0] m;
    if (!neg) begin
      if (big || val[32] || val[31]) m = 32'h7FFF_FFFF;
      else m = val[31:0];
      sat_sign = m;
    end else begin
      if (big || val[32] || (val[31] && |val[30:0])) m = 32'h8000_0000;
      else m = val[31:0];
      sat_sign = 32'd0 - m;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en[HE+4]) begin
      res.real_out <= $signed(sat_sign(v_re, big_re, neg_re_c));
      res.imag_out <= $signed(sat_sign(v_im, big_im, neg_im_c));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ce_recip.sv =====
// Three-stage floor division of a scaled input by a constant, with remainder.
`default_nettype none
module ce_recip import ce_pkg::*; #(
  parameter int          IN_FRAC_BITS = 12,
  parameter int          KW           = 6,
  parameter logic [30:0] DIVISOR      = LN2_Q30
) (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic signed [15:0]   a,
  output logic signed [KW-1:0] quo,
  output logic [30:0]          rem
);

  localparam int MW = 33 - IN_FRAC_BITS;
  localparam logic [MW-1:0] MUL = MW'((64'd1 << (62 - IN_FRAC_BITS)) / 64'(DIVISOR));
  localparam int PW = 17 + MW;
  localparam int RW = 46 - IN_FRAC_BITS;

  logic signed [PW-1:0] prod;
  logic signed [15:0]   a1;
  logic signed [KW-1:0] qe_c;
  logic signed [RW-1:0] xs;
  logic signed [RW-1:0] dv;
  logic signed [KW-1:0] qe2;
  logic signed [RW-1:0] r2;

  assign qe_c = KW'(prod >>> 32);
  assign xs   = RW'(a1) <<< (30 - IN_FRAC_BITS);
  assign dv   = $signed(RW'(DIVISOR));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PW'(a) * $signed({1'b0, MUL});
      a1   <= a;
    end
    if (en[1]) begin
      qe2 <= qe_c;
      r2  <= xs - RW'(qe_c) * dv;
    end
    if (en[2]) begin
      if (r2 < 0) begin
        quo <= qe2 - KW'(1);
        rem <= 31'(r2 + dv);
      end else if (r2 >= dv) begin
        quo <= qe2 + KW'(1);
        rem <= 31'(r2 - dv);
      end else begin
        quo <= qe2;
        rem <= 31'(r2);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ce_hstep.sv =====
// One Horner step: acc_out = 1 +/- ((acc * m) >> 30) / DIV over three stages.
`default_nettype none
module ce_hstep import ce_pkg::*; #(
  parameter int unsigned DIV = 1,
  parameter bit          ADD = 1'b1
) (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [30:0] acc_in,
  input  logic [29:0] m_in,
  output logic [30:0] acc_out,
  output logic [29:0] m_out
);

  localparam logic [32:0] RCP = 33'((64'd1 << 32) / 64'(DIV));
  localparam logic [30:0] DV  = 31'(DIV);

  logic [60:0] pa_full;
  logic [30:0] pa1;
  logic [29:0] m1;
  logic [63:0] qprod;
  logic [30:0] pa2;
  logic [30:0] qe2;
  logic [29:0] m2;
  logic [30:0] rm;
  logic [30:0] q;

  assign pa_full = 61'(acc_in) * 61'(m_in);
  assign qprod   = 64'(pa1) * 64'(RCP);
  assign rm      = pa2 - 31'(qe2 * DV);
  assign q       = (rm >= DV) ? qe2 + 31'd1 : qe2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa1 <= pa_full[60:30];
      m1  <= m_in;
    end
    if (en[1]) begin
      pa2 <= pa1;
      qe2 <= qprod[62:32];
      m2  <= m1;
    end
    if (en[2]) begin
      acc_out <= ADD ? ONE_Q30 + q : ONE_Q30 - q;
      m_out   <= m2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ce_chk.sv =====
// Port-level checker for the complex exponential pipeline, bound to the top level.
`default_nettype none
module ce_chk import ce_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic arg_valid,
  input wire logic arg_stall,
  input wire arg_t arg,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire res_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_free_flow: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || !res_stall) |-> !arg_stall)
    else $error("input stalled while output drains");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> res_valid)
    else $error("result beat dropped under stall");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> $stable(res))
    else $error("result beat changed under stall");

endmodule

bind complex_exponential ce_chk u_chk (
  .clk(clk), .rst(rst), .arg_valid(arg_valid), .arg_stall(arg_stall), .arg(arg),
  .res_valid(res_valid), .res_stall(res_stall), .res(res)
);
`default_nettype wire
